// ----- rtl/ftu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ftu_pkg;

	localparam int RATIO_W = 11;	// quotient 0..1024, one bit per divider stage

	localparam logic [12:0] QUARTER_TURN = 13'd1024;
	localparam logic [12:0] HALF_TURN    = 13'd2048;
	localparam logic [12:0] FULL_TURN    = 13'd4096;

	typedef enum logic [1:0] {
		OP_SIN   = 2'd0,
		OP_COS   = 2'd1,
		OP_ATAN2 = 2'd2,
		OP_ORTHO = 2'd3
	} op_t;

	// control and sideband that travel beside each pipeline stage up to the scaling stage
	typedef struct packed {
		logic        valid;
		op_t         op;
		logic [11:0] angle;
		logic [7:0]  radius;
		logic        xneg;
		logic        yneg;
		logic        swp;
		logic        zero;
		logic [12:0] ang;	// atan2 angle, filled in by the atan stage
	} ctl_t;

	// quarter-wave sine, 64 angle units per step; index 17 pads the top entry
	function automatic logic [10:0] sine_tab(input logic [4:0] idx);
		logic [10:0] v;
		case (idx)
			5'd0:  v = 11'd0;
			5'd1:  v = 11'd100;
			5'd2:  v = 11'd200;
			5'd3:  v = 11'd297;
			5'd4:  v = 11'd392;
			5'd5:  v = 11'd483;
			5'd6:  v = 11'd569;
			5'd7:  v = 11'd650;
			5'd8:  v = 11'd724;
			5'd9:  v = 11'd792;
			5'd10: v = 11'd851;
			5'd11: v = 11'd903;
			5'd12: v = 11'd946;
			5'd13: v = 11'd980;
			5'd14: v = 11'd1004;
			5'd15: v = 11'd1019;
			default: v = 11'd1024;
		endcase
		return v;
	endfunction

	// arctangent over ratio 0..1 in 16 steps; index 17 pads the top entry
	function automatic logic [9:0] atan_tab(input logic [4:0] idx);
		logic [9:0] v;
		case (idx)
			5'd0:  v = 10'd0;
			5'd1:  v = 10'd41;
			5'd2:  v = 10'd81;
			5'd3:  v = 10'd121;
			5'd4:  v = 10'd160;
			5'd5:  v = 10'd197;
			5'd6:  v = 10'd234;
			5'd7:  v = 10'd269;
			5'd8:  v = 10'd302;
			5'd9:  v = 10'd334;
			5'd10: v = 10'd364;
			5'd11: v = 10'd393;
			5'd12: v = 10'd419;
			5'd13: v = 10'd445;
			5'd14: v = 10'd469;
			5'd15: v = 10'd491;
			default: v = 10'd512;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/ftu_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ftu_div (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  ftu_pkg::ctl_t ctl_i,
	input  logic [21:0]  num_i,
	input  logic [11:0]  den_i,
	output ftu_pkg::ctl_t ctl_o,
	output logic [10:0]  ratio_o
);

	ftu_pkg::ctl_t ctl_s [0:ftu_pkg::RATIO_W-1];
	logic [21:0]   rem_s [0:ftu_pkg::RATIO_W-1];
	logic [11:0]   den_s [0:ftu_pkg::RATIO_W-1];
	logic [10:0]   quo_s [0:ftu_pkg::RATIO_W-1];

	// restoring division, most significant quotient bit first
	for (genvar i = 0; i < ftu_pkg::RATIO_W; i++) begin : g_stage
		localparam int SH = ftu_pkg::RATIO_W - 1 - i;
		ftu_pkg::ctl_t c_in;
		logic [21:0]   r_in;
		logic [11:0]   d_in;
		logic [10:0]   q_in;
		logic [22:0]   diff;

		if (i == 0) begin : g_first
			assign c_in = ctl_i;
			assign r_in = num_i;
			assign d_in = den_i;
			assign q_in = '0;
		end else begin : g_next
			assign c_in = ctl_s[i-1];
			assign r_in = rem_s[i-1];
			assign d_in = den_s[i-1];
			assign q_in = quo_s[i-1];
		end

		assign diff = {1'b0, r_in} - (23'(d_in) << SH);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[i] <= '0;
			end else if (en) begin
				ctl_s[i] <= c_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= diff[22] ? r_in : diff[21:0];
				den_s[i] <= d_in;
				quo_s[i] <= {q_in[9:0], ~diff[22]};
			end
		end
	end

	assign ctl_o   = ctl_s[ftu_pkg::RATIO_W-1];
	assign ratio_o = quo_s[ftu_pkg::RATIO_W-1];

endmodule

`default_nettype wire

// ----- rtl/ftu_atan.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ftu_atan (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  ftu_pkg::ctl_t ctl_i,
	input  logic [10:0]  ratio_i,
	output ftu_pkg::ctl_t ctl_o
);

	ftu_pkg::ctl_t ctl_s1, ctl_s2, ctl_s3;
	logic [9:0]    t0_s1, t1_s1;
	logic [3:0]    f_s1;
	logic [13:0]   acc_s2;

	logic [4:0]    idx;
	logic [4:0]    w0;
	logic [14:0]   p0, p1;
	logic [13:0]   rnd;
	logic [9:0]    oct;
	logic [12:0]   a1, a2, a3;
	ftu_pkg::ctl_t ctl_c;

	// table position: ratio / 64, sixteen sub-steps per entry
	assign idx = ratio_i[10:6];

	assign w0 = 5'd16 - {1'b0, f_s1};
	assign p0 = t0_s1 * w0;
	assign p1 = t1_s1 * f_s1;

	// round, then unfold by swap and quadrant
	always_comb begin
		rnd = acc_s2 + 14'd8;
		oct = rnd[13:4];
		a1  = ctl_s2.swp  ? ftu_pkg::QUARTER_TURN - {3'd0, oct} : {3'd0, oct};
		a2  = ctl_s2.xneg ? ftu_pkg::HALF_TURN - a1 : a1;
		a3  = ctl_s2.yneg ? ftu_pkg::FULL_TURN - a2 : a2;
		ctl_c     = ctl_s2;
		ctl_c.ang = ctl_s2.zero ? 13'd0 : a3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_i;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t0_s1  <= ftu_pkg::atan_tab(idx);
			t1_s1  <= ftu_pkg::atan_tab(idx + 5'd1);
			f_s1   <= ratio_i[5:2];
			acc_s2 <= 14'(p0 + p1);
		end
	end

	assign ctl_o = ctl_s3;

endmodule

`default_nettype wire

// ----- rtl/ftu_sine.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ftu_sine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  ftu_pkg::ctl_t      ctl_i,
	input  logic [11:0]        ang_a_i,
	input  logic [11:0]        ang_b_i,
	output ftu_pkg::ctl_t      ctl_o,
	output logic signed [11:0] sin_a_o,
	output logic signed [11:0] sin_b_o
);

	ftu_pkg::ctl_t      ctl_s1, ctl_s2, ctl_s3;
	logic [11:0]        ang_l [0:1];
	logic [10:0]        t0_s1 [0:1];
	logic [10:0]        t1_s1 [0:1];
	logic [5:0]         f_s1  [0:1];
	logic               neg_s1 [0:1];
	logic [16:0]        acc_s2 [0:1];
	logic               neg_s2 [0:1];
	logic signed [11:0] sin_s3 [0:1];

	assign ang_l[0] = ang_a_i;
	assign ang_l[1] = ang_b_i;

	for (genvar l = 0; l < 2; l++) begin : g_lane
		logic        neg;
		logic [11:0] a1, a2;
		logic [6:0]  w0;
		logic [16:0] p0, p1;
		logic [16:0] rnd;
		logic [10:0] mag;

		// fold to the first quadrant
		assign neg = ang_l[l] > 12'd2048;
		assign a1  = neg ? ang_l[l] - 12'd2048 : ang_l[l];
		assign a2  = (a1 > 12'd1024) ? 12'd2048 - a1 : a1;

		assign w0  = 7'd64 - {1'b0, f_s1[l]};
		assign p0  = t0_s1[l] * w0;
		assign p1  = t1_s1[l] * f_s1[l];

		assign rnd = acc_s2[l] + 17'd32;
		assign mag = rnd[16:6];

		always_ff @(posedge clk) begin
			if (en) begin
				t0_s1[l]  <= ftu_pkg::sine_tab(a2[10:6]);
				t1_s1[l]  <= ftu_pkg::sine_tab(a2[10:6] + 5'd1);
				f_s1[l]   <= a2[5:0];
				neg_s1[l] <= neg;
				acc_s2[l] <= p0 + p1;
				neg_s2[l] <= neg_s1[l];
				sin_s3[l] <= neg_s2[l] ? 12'sd0 - $signed({1'b0, mag}) : $signed({1'b0, mag});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_i;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	assign ctl_o   = ctl_s3;
	assign sin_a_o = sin_s3[0];
	assign sin_b_o = sin_s3[1];

endmodule

`default_nettype wire

// ----- rtl/ftu_scale.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ftu_scale (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  ftu_pkg::ctl_t      ctl_i,
	input  logic signed [11:0] sin_a_i,
	input  logic signed [11:0] sin_b_i,
	output logic               valid_o,
	output logic [13:0]        main_o,
	output logic [8:0]         second_o,
	output logic               zero_o
);

	ftu_pkg::ctl_t      ctl_s1;
	logic               valid_s2;
	logic signed [11:0] sin_a_s1;
	logic signed [20:0] pa_s1, pb_s1;
	logic [13:0]        main_s2;
	logic [8:0]         second_s2;
	logic               zero_s2;

	logic signed [8:0]  rad;
	logic [8:0]         ra, rb;
	logic [13:0]        main_c;
	logic [8:0]         second_c;
	logic               zero_c;

	assign rad = $signed({1'b0, ctl_i.radius});

	// round half away from zero, then divide by 1024
	function automatic logic [8:0] sym_round(input logic signed [20:0] p);
		logic [20:0] m;
		logic [20:0] s;
		logic [8:0]  r;
		m = p[20] ? 21'd0 - p : p;
		s = m + 21'd512;
		r = {1'b0, s[17:10]};
		return p[20] ? 9'd0 - r : r;
	endfunction

	assign ra = sym_round(pa_s1);
	assign rb = sym_round(pb_s1);

	always_comb begin
		second_c = '0;
		zero_c   = ctl_s1.zero;
		case (ctl_s1.op)
			ftu_pkg::OP_SIN, ftu_pkg::OP_COS: begin
				main_c = {{2{sin_a_s1[11]}}, sin_a_s1};
				zero_c = 1'b0;
			end
			ftu_pkg::OP_ATAN2: begin
				main_c = {1'b0, ctl_s1.ang};
			end
			ftu_pkg::OP_ORTHO: begin
				main_c   = {{5{ra[8]}}, ra};
				second_c = rb;
			end
			default: begin
				main_c = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1   <= '0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			ctl_s1   <= ctl_i;
			valid_s2 <= ctl_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sin_a_s1  <= sin_a_i;
			pa_s1     <= rad * sin_a_i;
			pb_s1     <= rad * sin_b_i;
			main_s2   <= main_c;
			second_s2 <= second_c;
			zero_s2   <= zero_c;
		end
	end

	assign valid_o  = valid_s2;
	assign main_o   = main_s2;
	assign second_o = second_s2;
	assign zero_o   = zero_s2;

endmodule

`default_nettype wire

// ----- rtl/fixed_point_trig_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel  Role      tdata                                        tuser
// s_*      items in  angle_in[11:0] x_value[23:12] y_value[35:24] operation[1:0]
//                    radius[43:36]
// m_*      items out main_result[13:0] second_result[22:14]       zero_vector
//
// One item per cycle sustained while m_tready does not stall the output.
// The path runs through the eleven-stage restoring divider of the atan2 ratio
// (one quotient bit per stage), followed by table, sine and scaling stages.
// Reset clears the control words with their valid bits and the output/skid flags only.
// An output register plus a one-item skid stage decouple the sides: s_tready
// drops only while the skid stage holds an item, and the whole pipe holds.

module fixed_point_trig_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,	// angle_in, x_value, y_value, radius, zero fill
	input  logic [1:0]  s_tuser,	// operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,	// main_result, second_result, zero fill
	output logic        m_tuser	// zero_vector
);

	logic          en;
	logic [11:0]   x, y, ax, ay, major, minor;
	logic          swp;
	ftu_pkg::ctl_t ctl_in, ctl_s1, ctl_div, ctl_atan, ctl_sin;
	logic [21:0]   num_s1;
	logic [11:0]   den_s1;
	logic [10:0]   ratio;
	logic [11:0]   ang_a, ang_b;
	logic signed [11:0] sin_a, sin_b;
	logic          res_valid;
	logic [13:0]   res_main;
	logic [8:0]    res_second;
	logic          res_zero;

	logic          out_v_q, skid_v_q;
	logic [13:0]   out_main_q, skid_main_q;
	logic [8:0]    out_second_q, skid_second_q;
	logic          out_zero_q, skid_zero_q;
	logic          push;

	assign en       = ~skid_v_q;
	assign s_tready = en;

	// fold the vector into the first octant
	always_comb begin
		x     = s_tdata[23:12];
		y     = s_tdata[35:24];
		ax    = x[11] ? 12'd0 - x : x;
		ay    = y[11] ? 12'd0 - y : y;
		swp   = ay > ax;
		major = swp ? ay : ax;
		minor = swp ? ax : ay;
		ctl_in.valid  = s_tvalid;
		ctl_in.op     = ftu_pkg::op_t'(s_tuser);
		ctl_in.angle  = s_tdata[11:0];
		ctl_in.radius = s_tdata[43:36];
		ctl_in.xneg   = x[11];
		ctl_in.yneg   = y[11];
		ctl_in.swp    = swp;
		ctl_in.zero   = (major == 12'd0);
		ctl_in.ang    = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
		end
	end

	// numerator of round(1024 * minor / major)
	always_ff @(posedge clk) begin
		if (en) begin
			num_s1 <= {minor, 10'd0} + {11'd0, major[11:1]};
			den_s1 <= major;
		end
	end

	ftu_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctl_i   (ctl_s1),
		.num_i   (num_s1),
		.den_i   (den_s1),
		.ctl_o   (ctl_div),
		.ratio_o (ratio)
	);

	ftu_atan u_atan (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctl_i   (ctl_div),
		.ratio_i (ratio),
		.ctl_o   (ctl_atan)
	);

	// lane a: sine, cosine or x offset; lane b: y offset
	always_comb begin
		case (ctl_atan.op)
			ftu_pkg::OP_SIN: ang_a = ctl_atan.angle;
			ftu_pkg::OP_COS: ang_a = ctl_atan.angle + 12'd1024;
			default:         ang_a = 12'(ctl_atan.ang + ftu_pkg::HALF_TURN);
		endcase
		ang_b = 12'(ctl_atan.ang + ftu_pkg::QUARTER_TURN);
	end

	ftu_sine u_sine (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctl_i   (ctl_atan),
		.ang_a_i (ang_a),
		.ang_b_i (ang_b),
		.ctl_o   (ctl_sin),
		.sin_a_o (sin_a),
		.sin_b_o (sin_b)
	);

	ftu_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.ctl_i    (ctl_sin),
		.sin_a_i  (sin_a),
		.sin_b_i  (sin_b),
		.valid_o  (res_valid),
		.main_o   (res_main),
		.second_o (res_second),
		.zero_o   (res_zero)
	);

	assign push = en & res_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (m_tready || !out_v_q) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q  <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (m_tready || !out_v_q) begin
			if (skid_v_q) begin
				out_main_q   <= skid_main_q;
				out_second_q <= skid_second_q;
				out_zero_q   <= skid_zero_q;
			end else if (push) begin
				out_main_q   <= res_main;
				out_second_q <= res_second;
				out_zero_q   <= res_zero;
			end
		end else if (push) begin
			skid_main_q   <= res_main;
			skid_second_q <= res_second;
			skid_zero_q   <= res_zero;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {1'b0, out_second_q, out_main_q};
	assign m_tuser  = out_zero_q;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid stage holds an item while output register is empty");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && !m_tready))
		else $error("skid stage filled without an output stall");

	a_zero_angle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_zero_q) |-> (out_main_q == 14'd0))
		else $error("zero vector item with nonzero main result");

	a_main_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> ($signed(out_main_q) >= -14'sd1024 && $signed(out_main_q) <= 14'sd4096))
		else $error("main result out of range");

	a_second_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> ($signed(out_second_q) >= -9'sd255))
		else $error("second result out of range");

endmodule

`default_nettype wire
